@@ design/soe_pkg.sv @@
// Shared types, widths and codes for the set operation engine.
`default_nettype none
package soe_pkg;

  localparam int SET_DEPTH = 8;
  localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int ELEM_W    = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [1:0]               req_t;
  typedef logic [1:0]               status_t;
  typedef logic [2:0]               mode_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam req_t REQ_APPEND_A = 2'd0;
  localparam req_t REQ_APPEND_B = 2'd1;
  localparam req_t REQ_RUN      = 2'd2;
  localparam req_t REQ_CLEAR    = 2'd3;

  localparam status_t ST_ELEM  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam mode_t MODE_UNION = 3'd0;
  localparam mode_t MODE_INTER = 3'd1;
  localparam mode_t MODE_A_B   = 3'd2;
  localparam mode_t MODE_B_A   = 3'd3;
  localparam mode_t MODE_CART  = 3'd4;

endpackage
`default_nettype wire

@@ design/soe_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface soe_req_if;
  import soe_pkg::*;
  logic  valid;
  logic  ready;
  req_t  req_type;
  elem_t element;
  modport source (output valid, output req_type, output element, input ready);
  modport sink   (input valid, input req_type, input element, output ready);
endinterface

interface soe_res_if;
  import soe_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  elem_t   first_value;
  elem_t   second_value;
  logic    last;
  modport source (output valid, output status, output first_value, output second_value,
                  output last, input ready);
  modport sink   (input valid, input status, input first_value, input second_value,
                  input last, output ready);
endinterface
`default_nettype wire

@@ design/set_operation_engine.sv @@
// Set operation engine: two small element stores and a compare sequencer.
//
//   channel  | dir | payload
//   req      | in  | req_type, element
//   res      | out | status, first_value, second_value, last
//   cfg      | in  | cfg_wr_data (op_mode), strobe cfg_wr_en
//
// A run walks the stores with one equality compare per cycle while the res
// channel does not stall; an unused mode goes straight to the done state.
// Results pass a one-deep hold register so the final one carries last.
// A stalled res channel stalls the sequencer; req is not ready during a run.
// Synchronous active-high reset clears counts, op_mode and control state.
`default_nettype none
module set_operation_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  soe_req_if.sink             req,
  soe_res_if.source           res,
  input  wire logic           cfg_wr_en,
  input  wire soe_pkg::mode_t cfg_wr_data
);
  import soe_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EMIT_A = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam logic [1:0] K_DIFF  = 2'd0;
  localparam logic [1:0] K_INTER = 2'd1;
  localparam logic [1:0] K_CART  = 2'd2;

  elem_t a_store [SET_DEPTH];
  elem_t b_store [SET_DEPTH];

  logic [1:0] state;
  logic [1:0] kind;
  logic       sw;
  cnt_t       cnt_a;
  cnt_t       cnt_b;
  cnt_t       i;
  cnt_t       j;
  mode_t      op_mode;

  logic       pend_valid;
  elem_t      pend_first;
  elem_t      pend_second;

  logic       out_valid;
  status_t    out_status;
  elem_t      out_first;
  elem_t      out_second;
  logic       out_last;

  logic       out_free;
  logic       accept;
  elem_t      x_val;
  elem_t      y_val;
  cnt_t       nx;
  cnt_t       ny;
  logic       eq;
  logic       i_end;
  logic       j_end;
  logic       emit_want;
  elem_t      emit_second;
  logic       can_emit;
  logic       emit_en;
  logic       stall;
  logic       full_drop;

  logic       push_en;
  status_t    push_status;
  elem_t      push_first;
  elem_t      push_second;
  logic       push_last;

  assign out_free = !out_valid || res.ready;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && out_free;

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.first_value  = out_first;
  assign res.second_value = out_second;
  assign res.last         = out_last;

  assign x_val = sw ? b_store[i[IDX_W-1:0]] : a_store[i[IDX_W-1:0]];
  assign y_val = sw ? a_store[j[IDX_W-1:0]] : b_store[j[IDX_W-1:0]];
  assign nx    = sw ? cnt_b : cnt_a;
  assign ny    = sw ? cnt_a : cnt_b;
  assign eq    = (x_val == y_val);
  assign i_end = (i >= nx);
  assign j_end = (j >= ny);

  always_comb begin
    emit_want   = 1'b0;
    emit_second = '0;
    if (state == S_EMIT_A) begin
      emit_want = !i_end;
    end else if (state == S_SCAN && !i_end) begin
      case (kind)
        K_DIFF:  emit_want = j_end;
        K_INTER: emit_want = !j_end && eq;
        K_CART: begin
          emit_want   = !j_end;
          emit_second = y_val;
        end
        default: emit_want = 1'b0;
      endcase
    end
  end

  assign can_emit = !pend_valid || out_free;
  assign emit_en  = emit_want && can_emit;
  assign stall    = emit_want && !can_emit;

  assign full_drop = accept &&
                     ((req.req_type == REQ_APPEND_A && cnt_a >= CNT_W'(SET_DEPTH)) ||
                      (req.req_type == REQ_APPEND_B && cnt_b >= CNT_W'(SET_DEPTH)));

  always_comb begin
    push_en     = 1'b0;
    push_status = ST_ELEM;
    push_first  = pend_first;
    push_second = pend_second;
    push_last   = 1'b0;
    if (full_drop) begin
      push_en     = 1'b1;
      push_status = ST_FULL;
      push_first  = req.element;
      push_second = '0;
      push_last   = 1'b1;
    end else if (emit_en && pend_valid) begin
      push_en = 1'b1;
    end else if (state == S_DONE && out_free) begin
      push_en   = 1'b1;
      push_last = 1'b1;
      if (!pend_valid) begin
        push_status = ST_EMPTY;
        push_first  = '0;
        push_second = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_APPEND_A && cnt_a < CNT_W'(SET_DEPTH)) begin
      a_store[cnt_a[IDX_W-1:0]] <= req.element;
    end
    if (accept && req.req_type == REQ_APPEND_B && cnt_b < CNT_W'(SET_DEPTH)) begin
      b_store[cnt_b[IDX_W-1:0]] <= req.element;
    end
    if (push_en) begin
      out_status <= push_status;
      out_first  <= push_first;
      out_second <= push_second;
      out_last   <= push_last;
    end
    if (emit_en) begin
      pend_first  <= x_val;
      pend_second <= emit_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_DIFF;
      sw         <= 1'b0;
      cnt_a      <= '0;
      cnt_b      <= '0;
      i          <= '0;
      j          <= '0;
      op_mode    <= MODE_UNION;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        op_mode <= cfg_wr_data;
      end
      if (push_en) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_en) begin
        pend_valid <= 1'b1;
      end else if (state == S_DONE && out_free) begin
        pend_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            i  <= '0;
            j  <= '0;
            case (req.req_type)
              REQ_APPEND_A: begin
                if (cnt_a < CNT_W'(SET_DEPTH)) cnt_a <= cnt_a + CNT_W'(1);
              end
              REQ_APPEND_B: begin
                if (cnt_b < CNT_W'(SET_DEPTH)) cnt_b <= cnt_b + CNT_W'(1);
              end
              REQ_RUN: begin
                sw <= (op_mode == MODE_B_A);
                case (op_mode)
                  MODE_UNION: state <= S_EMIT_A;
                  MODE_INTER: begin
                    kind  <= K_INTER;
                    state <= S_SCAN;
                  end
                  MODE_A_B: begin
                    kind  <= K_DIFF;
                    state <= S_SCAN;
                  end
                  MODE_B_A: begin
                    kind  <= K_DIFF;
                    state <= S_SCAN;
                  end
                  MODE_CART: begin
                    kind  <= K_CART;
                    state <= S_SCAN;
                  end
                  default: state <= S_DONE;
                endcase
              end
              default: begin
                cnt_a <= '0;
                cnt_b <= '0;
              end
            endcase
          end
        end
        S_EMIT_A: begin
          if (i_end) begin
            i     <= '0;
            j     <= '0;
            sw    <= 1'b1;
            kind  <= K_DIFF;
            state <= S_SCAN;
          end else if (!stall) begin
            i <= i + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (i_end) begin
            state <= S_DONE;
          end else if (!stall) begin
            if (j_end || (kind == K_DIFF && eq)) begin
              i <= i + CNT_W'(1);
              j <= '0;
            end else begin
              j <= j + CNT_W'(1);
            end
          end
        end
        default: begin
          if (out_free) state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt_a <= CNT_W'(SET_DEPTH) && cnt_b <= CNT_W'(SET_DEPTH))
    else $error("set count beyond capacity");

  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held result left over after a run");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_RUN |=> state != S_IDLE)
    else $error("run transaction did not start the sequencer");

  a_done_push: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && out_last && state == S_IDLE)
    else $error("run end did not deliver a last result");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY) |-> out_last)
    else $error("single result without last");
`endif

endmodule
`default_nettype wire
